[hdl/imrs_pkg.sv]
// Shared types and constants for the I2C master with retry and receive stack.
// No dependencies.
package imrs_pkg;

    localparam int TX_DEPTH = 32;
    localparam int RX_DEPTH = 32;
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_PUSH  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_POP   = 3'd4;

    localparam logic [3:0] TRIES_RESET = 4'd5;

    typedef struct packed {
        logic [2:0] req_type;
        logic       sda_in;
        logic [6:0] target_addr;
        logic [5:0] byte_count;
        logic [7:0] wr_data;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       failed;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic [5:0] rx_count;
    } res_t;

endpackage

[hdl/imrs_front.sv]
// Front end: accepts request transactions into a two-entry queue.
// Depends on imrs_pkg.
module imrs_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  imrs_pkg::req_t  in_req,
    output logic            q_valid,
    input  logic            q_ready,
    output imrs_pkg::req_t  q_req
);
    import imrs_pkg::*;

    req_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Advance pointers and occupancy
    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_req;
        end
    end
endmodule

[hdl/imrs_engine.sv]
// Back end: I2C bit engine, transmit buffer and receive stack.
// Depends on imrs_pkg.
module imrs_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [3:0]      max_tries,
    input  logic            q_valid,
    output logic            q_ready,
    input  imrs_pkg::req_t  q_req,
    output logic            out_valid,
    input  logic            out_ready,
    output imrs_pkg::res_t  out_res
);
    import imrs_pkg::*;

    localparam logic [3:0] PH_IDLE = 4'd0, PH_START = 4'd1, PH_TX_LOW = 4'd2,
        PH_TX_HIGH = 4'd3, PH_TACK_LOW = 4'd4, PH_TACK_HIGH = 4'd5,
        PH_RX_LOW = 4'd6, PH_RX_HIGH = 4'd7, PH_RACK_LOW = 4'd8,
        PH_RACK_HIGH = 4'd9, PH_STOP_A = 4'd10, PH_STOP_B = 4'd11,
        PH_STOP_C = 4'd12, PH_RNACK_HIGH = 4'd13;
    localparam logic [1:0] OUT_OK = 2'd0, OUT_RETRY = 2'd1, OUT_FAIL = 2'd2;

    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_mem [RX_DEPTH];

    logic [3:0]       phase_reg, phase_next;
    logic [3:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;
    logic [TX_CW-1:0] bidx_reg, bidx_next;
    logic [3:0]       try_reg, try_next;
    logic [7:0]       addr_reg, addr_next;
    logic [TX_CW-1:0] len_reg, len_next;
    logic             aslot_reg, aslot_next;
    logic [1:0]       outc_reg, outc_next;
    logic             scl_reg, scl_next, sda_reg, sda_next;
    logic [TX_CW-1:0] txf_reg, txf_next;
    logic [RX_CW-1:0] rxf_reg, rxf_next;
    logic [7:0]       txd_reg;
    logic             txd_ok_reg;
    logic             rx_we;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [7:0]       pop_data_reg;
    logic             tx_we;

    logic             out_full_reg;
    res_t             res_reg;
    logic             done_c, fail_c, pop_c, go;
    logic             rd_c;
    logic [3:0]       lim;
    logic [3:0]       try_inc;
    logic [TX_CW-1:0] bidx_inc;
    logic [RX_CW-1:0] cnt_ext;

    assign go        = q_valid && q_ready;
    assign q_ready   = !out_full_reg || out_ready;
    assign out_valid = out_full_reg;
    assign rd_c      = addr_reg[0];
    assign lim       = (max_tries == 4'd0) ? 4'd1 : max_tries;
    assign try_inc   = try_reg + 4'd1;
    assign bidx_inc  = bidx_reg + 1'b1;

    // Next state of the bit engine and buffers
    always_comb begin
        phase_next = phase_reg; bit_next = bit_reg; shift_next = shift_reg;
        bidx_next = bidx_reg; try_next = try_reg; addr_next = addr_reg;
        len_next = len_reg; aslot_next = aslot_reg; outc_next = outc_reg;
        scl_next = scl_reg; sda_next = sda_reg;
        txf_next = txf_reg; rxf_next = rxf_reg;
        done_c = 1'b0; fail_c = 1'b0; pop_c = 1'b0;
        rx_we = 1'b0; tx_we = 1'b0;
        rx_waddr = rxf_reg[RX_AW-1:0];
        rx_raddr = rxf_reg[RX_AW-1:0] - 1'b1;
        if (go) begin
            priority case (q_req.req_type)
                REQ_TICK: begin
                    unique case (phase_reg)
                        PH_IDLE: begin scl_next = 1'b1; sda_next = 1'b1; end
                        PH_START: begin
                            scl_next = 1'b1; sda_next = 1'b0;
                            shift_next = addr_reg; bit_next = 4'd0;
                            bidx_next = '0; aslot_next = 1'b1; outc_next = OUT_OK;
                            phase_next = PH_TX_LOW;
                        end
                        PH_TX_LOW: begin
                            scl_next = 1'b0; sda_next = shift_reg[7];
                            phase_next = PH_TX_HIGH;
                        end
                        PH_TX_HIGH: begin
                            scl_next = 1'b1; sda_next = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next = bit_reg + 4'd1;
                            phase_next = (bit_reg == 4'd7) ? PH_TACK_LOW : PH_TX_LOW;
                        end
                        PH_TACK_LOW: begin
                            scl_next = 1'b0; sda_next = 1'b1;
                            phase_next = PH_TACK_HIGH;
                        end
                        PH_TACK_HIGH: begin
                            scl_next = 1'b1; sda_next = 1'b1;
                            if (q_req.sda_in) begin
                                if (rd_c) outc_next = OUT_RETRY;
                                else begin
                                    try_next = try_inc;
                                    outc_next = (try_inc >= lim) ? OUT_FAIL : OUT_RETRY;
                                end
                                phase_next = PH_STOP_A;
                            end else begin
                                if (!aslot_reg) bidx_next = bidx_inc;
                                aslot_next = 1'b0;
                                bit_next = 4'd0;
                                if ((aslot_reg ? bidx_reg : bidx_inc) < len_reg) begin
                                    if (rd_c) begin
                                        shift_next = 8'd0; phase_next = PH_RX_LOW;
                                    end else begin
                                        shift_next = txd_ok_reg ? txd_reg : 8'd0;
                                        phase_next = PH_TX_LOW;
                                    end
                                end else phase_next = PH_STOP_A;
                            end
                        end
                        PH_RX_LOW: begin
                            scl_next = 1'b0; sda_next = 1'b1;
                            phase_next = PH_RX_HIGH;
                        end
                        PH_RX_HIGH: begin
                            scl_next = 1'b1; sda_next = 1'b1;
                            shift_next = {shift_reg[6:0], q_req.sda_in};
                            bit_next = bit_reg + 4'd1;
                            phase_next = (bit_reg == 4'd7) ? PH_RACK_LOW : PH_RX_LOW;
                        end
                        PH_RACK_LOW: begin
                            scl_next = 1'b0;
                            if (rxf_reg < RX_CW'(RX_DEPTH)) begin
                                rx_we = 1'b1; rxf_next = rxf_reg + 1'b1;
                                sda_next = 1'b0; phase_next = PH_RACK_HIGH;
                            end else begin
                                sda_next = 1'b1; phase_next = PH_RNACK_HIGH;
                            end
                        end
                        PH_RACK_HIGH: begin
                            scl_next = 1'b1; sda_next = 1'b0;
                            bidx_next = bidx_inc; bit_next = 4'd0; shift_next = 8'd0;
                            phase_next = (bidx_inc < len_reg) ? PH_RX_LOW : PH_STOP_A;
                        end
                        PH_RNACK_HIGH: begin
                            scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_STOP_A;
                        end
                        PH_STOP_A: begin
                            scl_next = 1'b0; sda_next = 1'b0; phase_next = PH_STOP_B;
                        end
                        PH_STOP_B: begin
                            scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_STOP_C;
                        end
                        PH_STOP_C: begin
                            scl_next = 1'b1; sda_next = 1'b1;
                            if (outc_reg == OUT_RETRY) phase_next = PH_START;
                            else begin
                                done_c = 1'b1; fail_c = (outc_reg == OUT_FAIL);
                                if (!rd_c) txf_next = '0;
                                phase_next = PH_IDLE;
                            end
                        end
                        default: begin
                            scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_IDLE;
                        end
                    endcase
                end
                REQ_PUSH: begin
                    if (!((phase_reg != PH_IDLE) && !rd_c) &&
                        txf_reg < TX_CW'(TX_DEPTH)) begin
                        tx_we = 1'b1; txf_next = txf_reg + 1'b1;
                    end
                end
                REQ_WRITE, REQ_READ: begin
                    if (phase_reg == PH_IDLE) begin
                        addr_next = {q_req.target_addr, q_req.req_type == REQ_READ};
                        if (q_req.req_type == REQ_WRITE &&
                            {1'b0, q_req.byte_count} > 7'(TX_DEPTH))
                            len_next = TX_CW'(TX_DEPTH);
                        else len_next = TX_CW'(q_req.byte_count);
                        try_next = 4'd0; bidx_next = '0; bit_next = 4'd0;
                        outc_next = OUT_OK; phase_next = PH_START;
                    end
                end
                REQ_POP: begin
                    if (rxf_reg != '0) begin
                        rxf_next = rxf_reg - 1'b1; pop_c = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; bit_reg <= 4'd0; shift_reg <= 8'd0;
            bidx_reg <= '0; try_reg <= 4'd0; addr_reg <= 8'd0; len_reg <= '0;
            aslot_reg <= 1'b0; outc_reg <= OUT_OK; scl_reg <= 1'b1; sda_reg <= 1'b1;
            txf_reg <= '0; rxf_reg <= '0; out_full_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; bit_reg <= bit_next; shift_reg <= shift_next;
            bidx_reg <= bidx_next; try_reg <= try_next; addr_reg <= addr_next;
            len_reg <= len_next; aslot_reg <= aslot_next; outc_reg <= outc_next;
            scl_reg <= scl_next; sda_reg <= sda_next;
            txf_reg <= txf_next; rxf_reg <= rxf_next;
            if (go) out_full_reg <= 1'b1;
            else if (out_ready) out_full_reg <= 1'b0;
        end
    end

    // Prefetch the next transmit byte; its index is bidx after this tick, plus one past the address slot
    logic [TX_CW-1:0] pf_idx;
    assign pf_idx = (phase_next == PH_START || aslot_next) ? bidx_next : bidx_next + 1'b1;
    always_ff @(posedge aclk) begin
        if (tx_we) tx_mem[txf_reg[TX_AW-1:0]] <= q_req.wr_data;
        txd_reg    <= tx_mem[pf_idx[TX_AW-1:0]];
        txd_ok_reg <= 1'b1;
    end

    // Receive stack write; read the top entry on each transaction and hold it
    always_ff @(posedge aclk) begin
        if (rx_we) rx_mem[rx_waddr] <= shift_reg;
        if (go) pop_data_reg <= rx_mem[rx_raddr];
    end

    // Result register; popped byte comes from the held stack read
    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg.scl_level <= scl_next;
            res_reg.sda_level <= sda_next;
            res_reg.busy_res  <= (phase_next != PH_IDLE);
            res_reg.done_res  <= done_c;
            res_reg.failed    <= fail_c;
            res_reg.rd_valid  <= pop_c;
            res_reg.rx_count  <= cnt_ext[5:0];
            res_reg.rd_data   <= 8'd0;
        end
    end

    always_comb begin
        out_res = res_reg;
        if (res_reg.rd_valid) out_res.rd_data = pop_data_reg;
    end

    assign cnt_ext = rxf_next;
endmodule

[hdl/i2c_master_with_retry_and_rx_stack_top.sv]
// Top level of the I2C master with retry and receive stack; depends on imrs_pkg,
// imrs_front and imrs_engine. Every request transaction (tick, push, start write,
// start read, pop) gives exactly one status transaction, in order. A request
// is registered in the front queue and then in the engine's result register before
// its status is valid; while m_ready stays high one request per cycle is sustained
// back to back. While m_ready is low the status is held and the engine
// stalls; the two-entry front queue fills up before s_ready drops.
// Write the tries register only while no transaction is in flight.
module i2c_master_with_retry_and_rx_stack_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic       s_sda_in,
    input  logic [6:0] s_target_addr,
    input  logic [5:0] s_byte_count,
    input  logic [7:0] s_wr_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic       m_failed,
    output logic [7:0] m_rd_data,
    output logic       m_rd_valid,
    output logic [5:0] m_rx_count
);
    import imrs_pkg::*;

    logic [3:0] tries_reg;
    req_t       in_req, q_req;
    res_t       res;
    logic       q_valid, q_ready;

    assign in_req = '{s_req_type, s_sda_in, s_target_addr, s_byte_count, s_wr_data};

    // Hold the try limit
    always_ff @(posedge aclk) begin
        if (!aresetn) tries_reg <= TRIES_RESET;
        else if (cfg_we) tries_reg <= cfg_wdata;
    end

    imrs_front u_front (.aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .in_req, .q_valid, .q_ready, .q_req);

    imrs_engine u_engine (.aclk, .aresetn, .max_tries(tries_reg), .q_valid, .q_ready,
        .q_req, .out_valid(m_valid), .out_ready(m_ready), .out_res(res));

    assign m_scl_level = res.scl_level;
    assign m_sda_level = res.sda_level;
    assign m_busy_res  = res.busy_res;
    assign m_done_res  = res.done_res;
    assign m_failed    = res.failed;
    assign m_rd_data   = res.rd_data;
    assign m_rd_valid  = res.rd_valid;
    assign m_rx_count  = res.rx_count;

`ifndef ASSERT_OFF
    a_fail_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failed |-> m_done_res) else $error("failed without done");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res) else $error("done while busy");
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rd_valid |-> m_rd_data == 8'd0) else $error("stray rd_data");
`endif
endmodule
